@@ design/halton_2d_sample_generator_top_defines.svh @@
// assertion macros for the halton sample generator
`ifndef HALTON_2D_SAMPLE_GENERATOR_TOP_DEFINES_SVH
`define HALTON_2D_SAMPLE_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define HSG_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsg assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define HSG_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsg assertion failed");

`endif

@@ design/hsg_pkg.sv @@
`default_nettype none

package hsg_pkg;

    localparam int IDX_W      = 32;
    localparam int FRAC_W     = 32;
    localparam int TRI_W      = 34;
    localparam int TERN_CELLS = 21;

    localparam logic [IDX_W-1:0] RECIP3 = 32'hAAAAAAAB;

    typedef struct packed {
        logic [IDX_W-1:0]  rest;
        logic [TRI_W-1:0]  rev;
        logic [TRI_W-1:0]  den;
        logic [FRAC_W-1:0] u;
    } tern_word_t;

    typedef struct packed {
        logic [TRI_W-1:0]  rem;
        logic [TRI_W-1:0]  den;
        logic [FRAC_W-1:0] quo;
        logic [FRAC_W-1:0] u;
    } div_word_t;

endpackage

`default_nettype wire

@@ design/hsg_index_if.sv @@
`default_nettype none

interface hsg_index_if;
    import hsg_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink (input valid, input sample_index, output ready);
endinterface

`default_nettype wire

@@ design/hsg_point_if.sv @@
`default_nettype none

interface hsg_point_if;
    import hsg_pkg::*;

    logic              valid;
    logic              ready;
    logic [FRAC_W-1:0] coord_u;
    logic [FRAC_W-1:0] coord_v;

    modport source (output valid, output coord_u, output coord_v, input ready);
    modport sink (input valid, input coord_u, input coord_v, output ready);
endinterface

`default_nettype wire

@@ design/halton_2d_sample_generator_top.sv @@
// path: an index word passes 21 ternary digit cells, then one cell per quotient bit
// throughput: one word per cycle while the result is not stalled
// a stalled result freezes the whole cell chain and holds off new index words
// reset: asynchronous, active low, clears only the valid bits of the chain
`default_nettype none

module halton_2d_sample_generator_top
    import hsg_pkg::*;
#(
    parameter int INDEX_BITS    = 32,
    parameter int FRACTION_BITS = 32
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hsg_index_if.sink   indices,
    hsg_point_if.source points
);

    localparam logic [2*IDX_W-1:0] IDX_MASK = (64'd1 << INDEX_BITS) - 64'd1;
    localparam int                 U_SHIFT  = FRAC_W - FRACTION_BITS;

    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [FRAC_W-1:0] flipped;
    logic [FRAC_W-1:0] coord_u_in;
    tern_word_t        head_word;
    div_word_t         div_head;

    logic              tv [0:TERN_CELLS];
    tern_word_t        tw [0:TERN_CELLS];
    logic              dv [0:FRACTION_BITS];
    div_word_t         dw [0:FRACTION_BITS];

    always_comb
    begin
        idx = indices.sample_index & IDX_MASK[IDX_W-1:0];
        for (int i = 0; i < FRAC_W; i++)
        begin
            flipped[i] = idx[IDX_W-1-i];
        end
        coord_u_in     = flipped >> U_SHIFT;
        head_word.rest = idx;
        head_word.rev  = '0;
        head_word.den  = {{(TRI_W-1){1'b0}}, 1'b1};
        head_word.u    = coord_u_in;
    end

    assign en     = !(dv[FRACTION_BITS] && !points.ready);
    assign tv[0]  = indices.valid;
    assign tw[0]  = head_word;

    assign indices.ready = en;

    genvar k;
    generate
        for (k = 0; k < TERN_CELLS; k++)
        begin : g_tern
            hsg_tern_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (tv[k]),
                .in_word   (tw[k]),
                .out_valid (tv[k+1]),
                .out_word  (tw[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        div_head.rem = tw[TERN_CELLS].rev;
        div_head.den = tw[TERN_CELLS].den;
        div_head.quo = '0;
        div_head.u   = tw[TERN_CELLS].u;
    end

    assign dv[0] = tv[TERN_CELLS];
    assign dw[0] = div_head;

    generate
        for (k = 0; k < FRACTION_BITS; k++)
        begin : g_div
            hsg_div_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (dv[k]),
                .in_word   (dw[k]),
                .out_valid (dv[k+1]),
                .out_word  (dw[k+1])
            );
        end
    endgenerate

    assign points.valid   = dv[FRACTION_BITS];
    assign points.coord_u = dw[FRACTION_BITS].u;
    assign points.coord_v = dw[FRACTION_BITS].quo;

endmodule

`default_nettype wire

@@ design/hsg_tern_cell.sv @@
`default_nettype none

module hsg_tern_cell
    import hsg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  tern_word_t      in_word,
    output logic            out_valid,
    output tern_word_t      out_word
);

    logic                  valid_reg;
    tern_word_t            word_reg;
    tern_word_t            word_next;
    logic [2*IDX_W-1:0]    prod;
    logic [IDX_W-1:0]      quot;
    logic [IDX_W-1:0]      rem3;
    logic [1:0]            digit;

    // divide by three through the reciprocal, exact for 32-bit values
    always_comb
    begin
        prod      = {{IDX_W{1'b0}}, in_word.rest} * {{IDX_W{1'b0}}, RECIP3};
        quot      = {1'b0, prod[2*IDX_W-1:IDX_W+1]};
        rem3      = in_word.rest - (quot + {quot[IDX_W-2:0], 1'b0});
        digit     = rem3[1:0];
        word_next = in_word;
        if (in_word.rest != '0)
        begin
            word_next.rest = quot;
            word_next.rev  = {in_word.rev[TRI_W-2:0], 1'b0} + in_word.rev
                             + {{(TRI_W-2){1'b0}}, digit};
            word_next.den  = {in_word.den[TRI_W-2:0], 1'b0} + in_word.den;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

@@ design/hsg_div_cell.sv @@
`default_nettype none

module hsg_div_cell
    import hsg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  div_word_t       in_word,
    output logic            out_valid,
    output div_word_t       out_word
);

    logic              valid_reg;
    div_word_t         word_reg;
    div_word_t         word_next;
    logic [TRI_W:0]    rem2;
    logic [TRI_W:0]    diff;

    // one restoring quotient bit
    always_comb
    begin
        rem2      = {in_word.rem, 1'b0};
        diff      = rem2 - {1'b0, in_word.den};
        word_next = in_word;
        if (rem2 >= {1'b0, in_word.den})
        begin
            word_next.rem = diff[TRI_W-1:0];
            word_next.quo = {in_word.quo[FRAC_W-2:0], 1'b1};
        end
        else
        begin
            word_next.rem = rem2[TRI_W-1:0];
            word_next.quo = {in_word.quo[FRAC_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

@@ design/hsg_checker.sv @@
`default_nettype none

`include "halton_2d_sample_generator_top_defines.svh"

module hsg_checker
    import hsg_pkg::*;
#(
    parameter int FRACTION_BITS = 32
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [FRAC_W-1:0] coord_u,
    input wire logic [FRAC_W-1:0] coord_v
);

    localparam logic [2*FRAC_W-1:0] LIMIT = 64'd1 << FRACTION_BITS;

    logic stalled;
    logic in_range;

    assign stalled  = out_valid && !out_ready;
    assign in_range = ({{FRAC_W{1'b0}}, coord_u} < LIMIT)
                      && ({{FRAC_W{1'b0}}, coord_v} < LIMIT);

    `HSG_ASSERT_NOW(a_stall_blocks_input, stalled, !in_ready)
    `HSG_ASSERT_NOW(a_input_held_only_on_stall, in_valid && !in_ready, stalled)
    `HSG_ASSERT_NOW(a_coord_in_range, out_valid, in_range)
    `HSG_ASSERT_NEXT(a_out_valid_holds, stalled, out_valid)
    `HSG_ASSERT_NEXT(a_out_word_holds, stalled, $stable(coord_u) && $stable(coord_v))

endmodule

bind halton_2d_sample_generator_top hsg_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_hsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (indices.valid),
    .in_ready  (indices.ready),
    .out_valid (points.valid),
    .out_ready (points.ready),
    .coord_u   (points.coord_u),
    .coord_v   (points.coord_v)
);

`default_nettype wire
